>>> design/lcpd_pkg.sv
// lcpd_pkg: shared types, codes, pattern tables and light thresholds
// for the led chaser with pwm dimming; no dependencies
package lcpd_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_STEP   = 2'd0,
        REQ_PWM    = 2'd1,
        REQ_LIGHT  = 2'd2,
        REQ_TOGGLE = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [2:0] CFG_CHASE_MODE = 3'd0;
    localparam logic [2:0] CFG_IVL_MODE1  = 3'd1;
    localparam logic [2:0] CFG_IVL_MODE2  = 3'd2;
    localparam logic [2:0] CFG_IVL_MODE3  = 3'd3;
    localparam logic [2:0] CFG_IVL_MODE4  = 3'd4;

    // chase modes
    localparam logic [2:0] MODE_SINGLE_FWD = 3'd1;
    localparam logic [2:0] MODE_SINGLE_BWD = 3'd2;
    localparam logic [2:0] MODE_PAIR_FWD   = 3'd3;
    localparam logic [2:0] MODE_PAIR_BWD   = 3'd4;

    localparam logic [3:0] IVL_RESET  = 4'd4;
    localparam logic [7:0] LED_ALL_OFF = 8'hff;

    // light thresholds, levels and duties
    localparam logic [7:0] LIGHT_TH1 = 8'd63;
    localparam logic [7:0] LIGHT_TH2 = 8'd126;
    localparam logic [7:0] LIGHT_TH3 = 8'd189;
    localparam logic [2:0] LEVEL_1 = 3'd1;
    localparam logic [2:0] LEVEL_2 = 3'd2;
    localparam logic [2:0] LEVEL_3 = 3'd3;
    localparam logic [2:0] LEVEL_4 = 3'd4;
    localparam logic [6:0] DUTY_1 = 7'd10;
    localparam logic [6:0] DUTY_2 = 7'd40;
    localparam logic [6:0] DUTY_3 = 7'd70;
    localparam logic [6:0] DUTY_4 = 7'd100;

    // configuration seen by the engine
    typedef struct packed {
        logic [2:0] chase_mode;
        logic [3:0] ivl1;
        logic [3:0] ivl2;
        logic [3:0] ivl3;
        logic [3:0] ivl4;
        logic       pos_clear;
    } cfg_t;

    // one lit led walking over eight places
    function automatic logic [7:0] single_pat(input logic [2:0] pos);
        logic [7:0] pat;
        pat = ~(8'd1 << pos);
        return pat;
    endfunction

    // mirrored pair over four places
    function automatic logic [7:0] pair_pat(input logic [1:0] pos);
        logic [7:0] pat;
        case (pos)
            2'd0:    pat = 8'he7;
            2'd1:    pat = 8'hdb;
            2'd2:    pat = 8'hbd;
            default: pat = 8'h7e;
        endcase
        return pat;
    endfunction

endpackage

>>> design/lcpd_cfg.sv
// lcpd_cfg: configuration registers and position-clear strobe
// depends on lcpd_pkg
module lcpd_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [3:0]        cfg_wdata,
    output lcpd_pkg::cfg_t    cfg
);
    import lcpd_pkg::*;

    logic [2:0] mode_reg, mode_next;
    logic [3:0] ivl1_reg, ivl1_next;
    logic [3:0] ivl2_reg, ivl2_next;
    logic [3:0] ivl3_reg, ivl3_next;
    logic [3:0] ivl4_reg, ivl4_next;
    logic       hit;

    // decode a write; indexes beyond the list are dropped
    always_comb
    begin
        mode_next = mode_reg;
        ivl1_next = ivl1_reg;
        ivl2_next = ivl2_reg;
        ivl3_next = ivl3_reg;
        ivl4_next = ivl4_reg;
        hit       = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHASE_MODE:
                begin
                    mode_next = cfg_wdata[2:0];
                    hit = 1'b1;
                end
                CFG_IVL_MODE1:
                begin
                    ivl1_next = cfg_wdata;
                    hit = 1'b1;
                end
                CFG_IVL_MODE2:
                begin
                    ivl2_next = cfg_wdata;
                    hit = 1'b1;
                end
                CFG_IVL_MODE3:
                begin
                    ivl3_next = cfg_wdata;
                    hit = 1'b1;
                end
                CFG_IVL_MODE4:
                begin
                    ivl4_next = cfg_wdata;
                    hit = 1'b1;
                end
                default: hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SINGLE_FWD;
            ivl1_reg <= IVL_RESET;
            ivl2_reg <= IVL_RESET;
            ivl3_reg <= IVL_RESET;
            ivl4_reg <= IVL_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            ivl1_reg <= ivl1_next;
            ivl2_reg <= ivl2_next;
            ivl3_reg <= ivl3_next;
            ivl4_reg <= ivl4_next;
        end
    end

    // clear strobe goes out with the write so the engine resets position
    assign cfg.chase_mode = mode_reg;
    assign cfg.ivl1       = ivl1_reg;
    assign cfg.ivl2       = ivl2_reg;
    assign cfg.ivl3       = ivl3_reg;
    assign cfg.ivl4       = ivl4_reg;
    assign cfg.pos_clear  = hit;

endmodule

>>> design/lcpd_engine.sv
// lcpd_engine: chaser state (run flag, step and pwm counters, position,
// duty, level, led) updated once per item; depends on lcpd_pkg
module lcpd_engine #(
    parameter int TICKS_PER_UNIT = 100,
    parameter int PWM_PERIOD     = 101
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lcpd_pkg::cfg_t    cfg,
    input  logic              item_go,
    input  lcpd_pkg::req_t    req_type,
    input  logic [7:0]        light_sample,
    output logic [7:0]        led_drive,
    output logic [2:0]        brightness_level,
    output logic              running
);
    import lcpd_pkg::*;

    localparam int SCW = $clog2(15 * TICKS_PER_UNIT + 1);
    localparam logic [6:0] PWM_LAST = 7'(PWM_PERIOD - 1);

    logic           run_reg, run_next;
    logic [SCW-1:0] step_reg, step_next;
    logic [2:0]     pos_reg, pos_next;
    logic [6:0]     pwm_reg, pwm_next;
    logic [6:0]     duty_reg, duty_next;
    logic [2:0]     level_reg, level_next;
    logic [7:0]     led_reg, led_next;

    logic [3:0]     ivl;
    logic           mode_ok;
    logic [SCW-1:0] step_inc;
    logic [SCW-1:0] thresh;
    logic [6:0]     pwm_inc;
    logic [7:0]     pattern;

    // interval and pattern for the current mode
    always_comb
    begin
        mode_ok = 1'b1;
        case (cfg.chase_mode)
            MODE_SINGLE_FWD: ivl = cfg.ivl1;
            MODE_SINGLE_BWD: ivl = cfg.ivl2;
            MODE_PAIR_FWD:   ivl = cfg.ivl3;
            MODE_PAIR_BWD:   ivl = cfg.ivl4;
            default:
            begin
                ivl = 4'd0;
                mode_ok = 1'b0;
            end
        endcase
        if (cfg.chase_mode inside {MODE_SINGLE_FWD, MODE_SINGLE_BWD})
            pattern = single_pat(pos_reg);
        else if (cfg.chase_mode inside {MODE_PAIR_FWD, MODE_PAIR_BWD})
            pattern = pair_pat(pos_reg[1:0]);
        else
            pattern = LED_ALL_OFF;
    end

    assign step_inc = step_reg + SCW'(1);
    assign thresh   = SCW'(ivl) * SCW'(TICKS_PER_UNIT);
    assign pwm_inc  = pwm_reg + 7'd1;

    // next state for one item
    always_comb
    begin
        run_next   = run_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        pwm_next   = pwm_reg;
        duty_next  = duty_reg;
        level_next = level_reg;
        led_next   = led_reg;
        if (item_go)
        begin
            case (req_type)
                REQ_STEP:
                begin
                    if (run_reg && mode_ok)
                    begin
                        if (step_inc >= thresh)
                        begin
                            step_next = '0;
                            case (cfg.chase_mode)
                                MODE_SINGLE_FWD: pos_next = pos_reg + 3'd1;
                                MODE_SINGLE_BWD: pos_next = pos_reg + 3'd7;
                                MODE_PAIR_FWD:   pos_next = {1'b0, pos_reg[1:0] + 2'd1};
                                default:         pos_next = {1'b0, pos_reg[1:0] + 2'd3};
                            endcase
                        end
                        else
                            step_next = step_inc;
                    end
                end
                REQ_PWM:
                begin
                    if (run_reg)
                    begin
                        if (pwm_inc < duty_reg)
                        begin
                            pwm_next = pwm_inc;
                            led_next = pattern;
                        end
                        else if (pwm_inc <= PWM_LAST)
                        begin
                            pwm_next = pwm_inc;
                            led_next = LED_ALL_OFF;
                        end
                        else
                        begin
                            pwm_next = 7'd0;
                            led_next = LED_ALL_OFF;
                        end
                    end
                end
                REQ_LIGHT:
                begin
                    if (light_sample < LIGHT_TH1)
                    begin
                        level_next = LEVEL_1;
                        duty_next  = DUTY_1;
                    end
                    else if (light_sample < LIGHT_TH2)
                    begin
                        level_next = LEVEL_2;
                        duty_next  = DUTY_2;
                    end
                    else if (light_sample <= LIGHT_TH3)
                    begin
                        level_next = LEVEL_3;
                        duty_next  = DUTY_3;
                    end
                    else
                    begin
                        level_next = LEVEL_4;
                        duty_next  = DUTY_4;
                    end
                end
                default: run_next = ~run_reg;
            endcase
        end
        // the user must make config writes only while idle; the block does not enforce it
        if (cfg.pos_clear)
            pos_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            step_reg  <= '0;
            pos_reg   <= 3'd0;
            pwm_reg   <= 7'd0;
            duty_reg  <= 7'd0;
            level_reg <= 3'd0;
            led_reg   <= LED_ALL_OFF;
        end
        else
        begin
            run_reg   <= run_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            pwm_reg   <= pwm_next;
            duty_reg  <= duty_next;
            level_reg <= level_next;
            led_reg   <= led_next;
        end
    end

    // result is the state after this item
    assign led_drive        = led_next;
    assign brightness_level = level_next;
    assign running          = run_next;

endmodule

>>> design/led_chaser_pwm_dimmer_core.sv
// led_chaser_pwm_dimmer_core: top level with input and result registers
// around the chaser engine; depends on lcpd_pkg, lcpd_cfg, lcpd_engine
//
//  channel   | direction | width   | contents
//  s_*       | in        | 8 + 2   | tdata light_sample, tuser req_type
//  m_*       | out       | 16      | tdata led_drive, brightness_level, running
//  cfg_*     | in        | 3 + 4   | register index and write data
//
// A word accepted into the input register passes through the engine into
// the result register; one item is taken per cycle while m_tready does not
// stall the result register.
// Reset clears both valid flags and all chaser state.
// A stalled m_tready holds the result; the input register still fills,
// then s_tready drops until the result is taken.
module led_chaser_pwm_dimmer_core #(
    parameter int TICKS_PER_UNIT = 100,
    parameter int PWM_PERIOD     = 101
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] light_sample
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] led_drive, [10:8] brightness_level,
                                   // [11] running, [15:12] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import lcpd_pkg::*;

    cfg_t       cfg;
    logic       in_vld_reg, in_vld_next;
    req_t       in_req_reg;
    logic [7:0] in_smp_reg;
    logic       out_vld_reg, out_vld_next;
    logic [11:0] out_data_reg;
    logic       adv;
    logic       item_go;
    logic [7:0] led_drive;
    logic [2:0] brightness_level;
    logic       running;

    lcpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcpd_engine #(
        .TICKS_PER_UNIT (TICKS_PER_UNIT),
        .PWM_PERIOD     (PWM_PERIOD)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .item_go          (item_go),
        .req_type         (in_req_reg),
        .light_sample     (in_smp_reg),
        .led_drive        (led_drive),
        .brightness_level (brightness_level),
        .running          (running)
    );

    // pipeline handshake
    assign adv       = !out_vld_reg || m_tready;
    assign item_go   = in_vld_reg && adv;
    assign s_tready  = !in_vld_reg || adv;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tready)
            in_vld_next = s_tvalid;
        out_vld_next = out_vld_reg;
        if (adv)
            out_vld_next = in_vld_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg <= req_t'(s_tuser);
            in_smp_reg <= s_tdata;
        end
        if (item_go)
            out_data_reg <= {running, brightness_level, led_drive};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule

>>> sim/tb_led_chaser_pwm_dimmer_core.sv
// tb_led_chaser_pwm_dimmer_core: self-checking bench for the led chaser with pwm dimming
// predicts every result word from its own model of the chaser and compares it field by field
// depends on lcpd_pkg and led_chaser_pwm_dimmer_core
module tb_led_chaser_pwm_dimmer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lcpd_pkg::*;

    localparam int TICKS_PER_UNIT  = 100;
    localparam int PWM_PERIOD      = 101;
    localparam int RESET_CYCLES    = 4;
    localparam int IDLE_PCT        = 22;
    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 188;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int CFG_REG_COUNT   = int'(CFG_IVL_MODE4) + 1;
    localparam logic [2:0] MODE_NONE = 3'd0;

    // lit patterns, position 0 in the lowest byte
    localparam logic [63:0] SINGLE_LEDS = 64'h7fbf_dfef_f7fb_fdfe;
    localparam logic [31:0] PAIR_LEDS   = 32'h7ebd_dbe7;

    typedef struct packed {
        logic [7:0] leds;
        logic [2:0] level;
        logic       running;
    } chaser_word_t;

    // model of the chaser state plus the result words still owed by the block
    class chaser_scoreboard;
        logic [2:0]   mode;
        logic [3:0]   ivl [1:4];
        bit           run;
        int unsigned  step_cnt;
        logic [2:0]   pos;
        logic [6:0]   pwm_cnt;
        logic [6:0]   duty;
        logic [2:0]   level;
        logic [7:0]   leds;
        chaser_word_t led_words_due [$];
        int           errors;
        int           n_words;
        int           n_moves;
        int           n_wraps;

        function new();
            mode = MODE_SINGLE_FWD;
            foreach (ivl[i]) ivl[i] = IVL_RESET;
            run      = 1'b0;
            step_cnt = 0;
            pos      = '0;
            pwm_cnt  = '0;
            duty     = '0;
            level    = '0;
            leds     = LED_ALL_OFF;
            errors   = 0;
            n_words  = 0;
            n_moves  = 0;
            n_wraps  = 0;
        endfunction

        function int pending();
            return led_words_due.size();
        endfunction

        // register write, any known index clears the position
        function void write_cfg(logic [2:0] idx, logic [3:0] val);
            case (idx)
                CFG_CHASE_MODE: mode   = val[2:0];
                CFG_IVL_MODE1:  ivl[1] = val;
                CFG_IVL_MODE2:  ivl[2] = val;
                CFG_IVL_MODE3:  ivl[3] = val;
                CFG_IVL_MODE4:  ivl[4] = val;
                default:        return;
            endcase
            pos = '0;
        endfunction

        function logic [7:0] lit_pattern();
            case (mode)
                MODE_SINGLE_FWD, MODE_SINGLE_BWD: return SINGLE_LEDS[{pos, 3'b000} +: 8];
                MODE_PAIR_FWD, MODE_PAIR_BWD:     return PAIR_LEDS[{pos[1:0], 3'b000} +: 8];
                default:                          return LED_ALL_OFF;
            endcase
        endfunction

        // step tick: count toward the mode's interval, then move one place
        function void step_tick();
            int unsigned span;
            if (!run) return;
            case (mode)
                MODE_SINGLE_FWD: span = ivl[1];
                MODE_SINGLE_BWD: span = ivl[2];
                MODE_PAIR_FWD:   span = ivl[3];
                MODE_PAIR_BWD:   span = ivl[4];
                default:         return;
            endcase
            span = span * TICKS_PER_UNIT;
            step_cnt++;
            if (step_cnt >= span) begin
                step_cnt = 0;
                n_moves++;
                case (mode)
                    MODE_SINGLE_FWD: pos = pos + 3'd1;
                    MODE_SINGLE_BWD: pos = pos - 3'd1;
                    MODE_PAIR_FWD:   pos = {1'b0, pos[1:0] + 2'd1};
                    default:         pos = {1'b0, pos[1:0] - 2'd1};
                endcase
            end
        endfunction

        // pwm tick: pattern on below duty, dark for the rest of the period
        function void pwm_tick();
            if (!run) return;
            pwm_cnt = pwm_cnt + 7'd1;
            if (pwm_cnt < duty) begin
                leds = lit_pattern();
            end
            else if (pwm_cnt <= 7'(PWM_PERIOD - 1)) begin
                leds = LED_ALL_OFF;
            end
            else begin
                pwm_cnt = '0;
                leds    = LED_ALL_OFF;
                n_wraps++;
            end
        endfunction

        function void set_light(logic [7:0] sample);
            if (sample < LIGHT_TH1) begin
                level = LEVEL_1;
                duty  = DUTY_1;
            end
            else if (sample < LIGHT_TH2) begin
                level = LEVEL_2;
                duty  = DUTY_2;
            end
            else if (sample <= LIGHT_TH3) begin
                level = LEVEL_3;
                duty  = DUTY_3;
            end
            else begin
                level = LEVEL_4;
                duty  = DUTY_4;
            end
        endfunction

        // accepted input word: update the model and queue the word it causes
        function void take_request(req_t kind, logic [7:0] sample);
            chaser_word_t w;
            case (kind)
                REQ_STEP:  step_tick();
                REQ_PWM:   pwm_tick();
                REQ_LIGHT: set_light(sample);
                default:   run = !run;
            endcase
            w.leds    = leds;
            w.level   = level;
            w.running = run;
            led_words_due.push_back(w);
        endfunction

        // accepted result word against the oldest one due
        function void match_led_word(logic [15:0] word);
            chaser_word_t w;
            n_words++;
            if (led_words_due.size() == 0) begin
                $error("result word %04h arrived with nothing due", word);
                errors++;
                return;
            end
            w = led_words_due.pop_front();
            if (word[7:0] !== w.leds) begin
                $error("led_drive: expected %02h, actual %02h", w.leds, word[7:0]);
                errors++;
            end
            if (word[10:8] !== w.level) begin
                $error("brightness_level: expected %0d, actual %0d", w.level, word[10:8]);
                errors++;
            end
            if (word[11] !== w.running) begin
                $error("running: expected %0b, actual %0b", w.running, word[11]);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;

    chaser_scoreboard sb;
    bit          no_idle      = 1'b0;
    int          rx_hold_reqs = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;
    int          stall_cycles = 0;

    led_chaser_pwm_dimmer_core #(
        .TICKS_PER_UNIT (TICKS_PER_UNIT),
        .PWM_PERIOD     (PWM_PERIOD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (rx_hold_left != 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_seen != rx_hold_reqs) begin
            m_tready     <= 1'b0;
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= RX_HOLD_CYCLES;
        end
        else begin
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // word monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n && sb != null) begin
            if (s_tvalid && s_tready) sb.take_request(req_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) sb.match_led_word(m_tdata);
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one input word, with random idle cycles ahead of it
    task automatic send_word(input req_t kind, input logic [7:0] sample);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // random word, step ticks weighted by step_pct
    task automatic send_random_word(input int step_pct);
        int   pick;
        req_t kind;
        pick = $urandom_range(99);
        if (pick < step_pct)  kind = REQ_STEP;
        else if (pick < 92)   kind = REQ_PWM;
        else if (pick < 97)   kind = REQ_LIGHT;
        else                  kind = REQ_TOGGLE;
        send_word(kind, 8'($urandom_range(255)));
    endtask

    // stop offering and wait for every word due, then optionally let the block settle
    task automatic drain_results(input bit settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_cfg(idx, val);
    endtask

    function automatic logic [3:0] mode_word(input logic [2:0] mode);
        return {1'($urandom_range(1)), mode};
    endfunction

    function automatic logic [3:0] rand_interval();
        if ($urandom_range(99) < 70) return 4'($urandom_range(2));
        return 4'($urandom_range(15));
    endfunction

    // register setting for each phase
    task automatic program_phase(input int phase);
        logic [2:0] bad_mode;
        case (phase)
            0: begin
                write_reg(CFG_CHASE_MODE, mode_word(MODE_SINGLE_FWD));
                write_reg(CFG_IVL_MODE1, 4'd0);
            end
            1: begin
                write_reg(CFG_CHASE_MODE, mode_word(MODE_SINGLE_BWD));
                write_reg(CFG_IVL_MODE2, 4'd1);
            end
            2: begin
                write_reg(CFG_CHASE_MODE, mode_word(MODE_PAIR_FWD));
                write_reg(CFG_IVL_MODE3, 4'd0);
            end
            3: begin
                write_reg(CFG_CHASE_MODE, mode_word(MODE_PAIR_BWD));
                write_reg(CFG_IVL_MODE4, 4'd0);
            end
            4: begin
                write_reg(CFG_CHASE_MODE, mode_word(MODE_SINGLE_FWD));
                write_reg(CFG_IVL_MODE1, 4'd15);
            end
            5: begin
                // lowered interval with the count already past it
                write_reg(CFG_IVL_MODE1, 4'd1);
            end
            6: begin
                bad_mode = ($urandom_range(3) == 0) ? MODE_NONE
                                                    : 3'(MODE_PAIR_BWD + $urandom_range(1, 3));
                write_reg(CFG_CHASE_MODE, mode_word(bad_mode));
                for (int k = CFG_REG_COUNT; k < 8; k++)
                    write_reg(3'(k), 4'($urandom_range(15)));
            end
            default: begin
                write_reg(CFG_IVL_MODE1, rand_interval());
                write_reg(CFG_IVL_MODE2, rand_interval());
                write_reg(CFG_IVL_MODE3, rand_interval());
                write_reg(CFG_IVL_MODE4, rand_interval());
                if ($urandom_range(99) < 80)
                    write_reg(CFG_CHASE_MODE,
                              mode_word(3'(MODE_SINGLE_FWD + $urandom_range(3))));
                else
                    write_reg(CFG_CHASE_MODE, 4'($urandom_range(15)));
                if ($urandom_range(1) == 1)
                    write_reg(3'($urandom_range(7, CFG_REG_COUNT)), 4'($urandom_range(15)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int step_pct;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stopped ticks, dark before sampling, light thresholds, stop and restart
        send_word(REQ_STEP, 8'($urandom_range(255)));
        send_word(REQ_PWM, 8'($urandom_range(255)));
        send_word(REQ_TOGGLE, 8'($urandom_range(255)));
        send_word(REQ_PWM, 8'($urandom_range(255)));
        send_word(REQ_LIGHT, 8'd0);
        send_word(REQ_LIGHT, LIGHT_TH1 - 8'd1);
        send_word(REQ_LIGHT, LIGHT_TH1);
        send_word(REQ_LIGHT, LIGHT_TH2 - 8'd1);
        send_word(REQ_LIGHT, LIGHT_TH2);
        send_word(REQ_LIGHT, LIGHT_TH3);
        send_word(REQ_LIGHT, LIGHT_TH3 + 8'd1);
        send_word(REQ_LIGHT, 8'hff);
        send_word(REQ_LIGHT, 8'd0);
        repeat (3) send_word(REQ_PWM, 8'($urandom_range(255)));
        repeat (2) send_word(REQ_STEP, 8'($urandom_range(255)));
        send_word(REQ_TOGGLE, 8'($urandom_range(255)));
        send_word(REQ_PWM, 8'($urandom_range(255)));
        send_word(REQ_STEP, 8'($urandom_range(255)));
        send_word(REQ_TOGGLE, 8'($urandom_range(255)));

        // random phases, one register setting each
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_results(1'b1);
            program_phase(phase);
            no_idle  = (phase == 1 || phase == 3);
            step_pct = (phase == 1 || phase == 4) ? 75 : 45;
            if (!sb.run) send_word(REQ_TOGGLE, 8'($urandom_range(255)));
            send_word(REQ_LIGHT, 8'($urandom_range(255)));
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // long result hold-off while inputs keep coming
                if ((phase == 2 || phase == 7) && n == 60) rx_hold_reqs++;
                // sender pause until every word due has come
                if (phase == 4 && n == 95) drain_results(1'b0);
                send_random_word(step_pct);
            end
        end

        drain_results(1'b1);
        $display("checked %0d result words over %0d register settings", sb.n_words, N_PHASES);
        $display("pattern moved %0d times, pwm period wrapped %0d times", sb.n_moves, sb.n_wraps);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
design/lcpd_pkg.sv
design/lcpd_cfg.sv
design/lcpd_engine.sv
design/led_chaser_pwm_dimmer_core.sv
sim/tb_led_chaser_pwm_dimmer_core.sv
